/* hw/rtl/vox_pkg.sv */
// Shared types and constants of the voxel chunk stream parser.
package vox_pkg;

   localparam logic [31:0] TAG_VOX  = 32'h20584F56;
   localparam logic [31:0] TAG_MAIN = 32'h4E49414D;
   localparam logic [31:0] TAG_SIZE = 32'h455A4953;
   localparam logic [31:0] TAG_XYZI = 32'h495A5958;
   localparam logic [31:0] TAG_RGBA = 32'h41424752;
   localparam logic [7:0]  LAST_PALETTE_ENTRY = 8'd255;

   localparam int unsigned QUEUE_DEPTH = 4;

   typedef enum logic [2:0] {
      KIND_SIZE      = 3'd0,
      KIND_VOXEL     = 3'd1,
      KIND_PALETTE   = 3'd2,
      KIND_END       = 3'd3,
      KIND_BAD_MAGIC = 3'd4,
      KIND_BAD_MAIN  = 3'd5
   } record_kind_type;

   // One record as it leaves the parser, before output formatting.
   typedef struct packed {
      record_kind_type kind;
      logic [31:0]     x;
      logic [31:0]     y;
      logic [31:0]     z;
      logic [7:0]      ci;
      logic [31:0]     rgba;
      logic            ps;
   } record_type;

endpackage

/* hw/rtl/vox_chunk_stream_parser.sv */
// Top level of the voxel chunk stream parser.
// A record is written into the record queue, then registered in the output stage before it appears on rsp_.
// Throughput: one byte per cycle while req_tready is high; the chunk walker never stalls on its own.
// req_tready drops only when the record queue is nearly full.
// Reset is synchronous and active high; it clears the walker, queue and output stage.
// After reset the first bytes are parsed as a file start.
module vox_chunk_stream_parser #(
   parameter int unsigned QueueDepth = vox_pkg::QUEUE_DEPTH
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [7:0]   req_tdata,  // data_byte
   input  logic         req_tuser,  // file_start
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // record_kind[2:0], coord_x[34:3], coord_y[66:35], coord_z[98:67],
   // color_index[106:99], rgba_word[138:107], palette_seen[139], zero fill
   output logic [143:0] rsp_tdata
);
   import vox_pkg::*;

   logic       rec_valid, room, q_valid, q_take;
   record_type rec_data, q_data;

   // The walker accepts a byte whenever the queue can absorb a record.
   vox_front u_front (
      .clock, .reset,
      .in_valid (req_tvalid), .in_ready (req_tready),
      .in_byte (req_tdata), .in_start (req_tuser),
      .rec_valid, .rec_data, .rec_room (room)
   );

   vox_queue #(.DEPTH(QueueDepth)) u_queue (
      .clock, .reset,
      .wr_valid (rec_valid), .wr_data (rec_data), .room,
      .rd_valid (q_valid), .rd_data (q_data), .rd_take (q_take)
   );

   vox_back u_back (
      .clock, .reset,
      .q_valid, .q_data, .q_take,
      .out_valid (rsp_tvalid), .out_ready (rsp_tready), .out_data (rsp_tdata)
   );

`ifndef NO_ASSERTIONS
   // A record is only produced for an accepted byte.
   a_rec_on_accept: assert property (@(posedge clock) disable iff (reset)
      rec_valid |-> (req_tvalid && req_tready)) else $error("record without byte");
   // The queue never gets a record while it has no room.
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      rec_valid |-> room) else $error("queue overflow");
   // A stalled result holds its payload.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)))
      else $error("result changed under stall");
`endif
endmodule

/* hw/rtl/vox_front.sv */
// Front part: byte-serial chunk walker that turns file bytes into records.
module vox_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  logic [7:0]          in_byte,
   input  logic                in_start,
   output logic                rec_valid,
   output vox_pkg::record_type rec_data,
   input  logic                rec_room
);
   import vox_pkg::*;

   typedef enum logic [3:0] {
      PH_MAGIC, PH_VERSION, PH_MAIN_ID, PH_MAIN_CONT, PH_MAIN_CHILD,
      PH_CH_ID, PH_CH_CONT, PH_CH_CHILD, PH_SIZE, PH_XYZI_CNT, PH_VOXEL,
      PH_RGBA, PH_SKIP, PH_END_PEND, PH_IDLE
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [31:0] pos_ff, pos_in;
   logic [1:0]  cnt_ff, cnt_in;
   logic [31:0] word_ff, word_in;
   logic [31:0] main_end_ff, main_end_in;
   logic [31:0] tag_ff, tag_in;
   logic [31:0] cont_ff, cont_in;
   logic [31:0] child_ff, child_in;
   logic [31:0] skip_ff, skip_in;
   logic [31:0] vox_ff, vox_in;
   logic [7:0]  slot_ff, slot_in;
   logic [31:0] hx_ff, hx_in;
   logic [31:0] hy_ff, hy_in;
   logic        flag_ff, flag_in;
   // Saturating end of MAIN, summed in two registered halves.
   logic [32:0] part_ff, part_in;

   assign in_ready = rec_room;

   always_comb begin
      logic [31:0] w;
      logic [33:0] e;
      logic        go;
      logic [31:0] sa, sb;
      logic        do_skip;
      phase_in = phase_ff; pos_in = pos_ff; cnt_in = cnt_ff; word_in = word_ff;
      main_end_in = main_end_ff; tag_in = tag_ff; cont_in = cont_ff;
      child_in = child_ff; skip_in = skip_ff; vox_in = vox_ff; slot_in = slot_ff;
      hx_in = hx_ff; hy_in = hy_ff; flag_in = flag_ff; part_in = part_ff;
      rec_valid = 1'b0;
      rec_data  = '0;
      w = '0; e = '0; sa = '0; sb = '0; do_skip = 1'b0;
      go = in_valid && rec_room;
      if (go) begin
         if (phase_ff == PH_END_PEND) begin
            rec_valid = 1'b1;
            rec_data.kind = KIND_END;
            rec_data.ps = flag_ff;
            phase_in = PH_IDLE;
         end
         if (in_start) begin
            phase_in = PH_MAGIC; pos_in = '0; cnt_in = '0; word_in = '0;
            main_end_in = '0; tag_in = '0; cont_in = '0; child_in = '0;
            skip_in = '0; vox_in = '0; slot_in = '0; hx_in = '0; hy_in = '0;
            flag_in = 1'b0;
         end
         if (phase_in != PH_IDLE) begin
            pos_in = pos_in + 32'd1;
            if (phase_in == PH_SKIP) begin
               skip_in = skip_in - 32'd1;
               if (skip_in == 32'd0) begin
                  do_skip = 1'b1; sa = child_in; sb = 32'd0;
               end
            end else begin
               word_in = {in_byte, word_in[31:8]};
               cnt_in = cnt_in + 2'd1;
               w = word_in;
               if (cnt_in == 2'd0) begin
                  case (phase_in)
                     PH_MAGIC: begin
                        if (w != TAG_VOX) begin
                           rec_valid = 1'b1; rec_data.kind = KIND_BAD_MAGIC;
                           phase_in = PH_IDLE;
                        end else phase_in = PH_VERSION;
                     end
                     PH_VERSION: phase_in = PH_MAIN_ID;
                     PH_MAIN_ID: begin
                        tag_in = w;
                        if (w != TAG_MAIN) begin
                           rec_valid = 1'b1; rec_data.kind = KIND_BAD_MAIN;
                           phase_in = PH_IDLE;
                        end else phase_in = PH_MAIN_CONT;
                     end
                     PH_MAIN_CONT: begin
                        cont_in = w;
                        // Position here is 16; the MAIN children word ends 20 bytes in.
                        part_in = {1'b0, w} + 33'd20;
                        phase_in = PH_MAIN_CHILD;
                     end
                     PH_MAIN_CHILD: begin
                        e = {1'b0, part_ff} + {2'b0, w};
                        main_end_in = (e[33:32] != 2'b0) ? 32'hFFFFFFFF : e[31:0];
                        do_skip = 1'b1; sa = cont_in; sb = 32'd0;
                     end
                     PH_CH_ID: begin tag_in = w; phase_in = PH_CH_CONT; end
                     PH_CH_CONT: begin cont_in = w; phase_in = PH_CH_CHILD; end
                     PH_CH_CHILD: begin
                        child_in = w;
                        if (tag_in == TAG_SIZE) begin
                           slot_in = '0; phase_in = PH_SIZE;
                        end else if (tag_in == TAG_XYZI) begin
                           phase_in = PH_XYZI_CNT;
                        end else if (tag_in == TAG_RGBA) begin
                           flag_in = 1'b1; slot_in = 8'd1; phase_in = PH_RGBA;
                        end else begin
                           do_skip = 1'b1; sa = cont_in; sb = w;
                        end
                     end
                     PH_SIZE: begin
                        if (slot_in == 8'd0) begin
                           hx_in = w; slot_in = 8'd1;
                        end else if (slot_in == 8'd1) begin
                           hy_in = w; slot_in = 8'd2;
                        end else begin
                           rec_valid = 1'b1; rec_data.kind = KIND_SIZE;
                           rec_data.x = hx_in; rec_data.y = hy_in; rec_data.z = w;
                           slot_in = '0;
                           do_skip = 1'b1; sa = child_in; sb = 32'd0;
                        end
                     end
                     PH_XYZI_CNT: begin
                        vox_in = w[31] ? 32'd0 : w;
                        if (vox_in == 32'd0) begin
                           do_skip = 1'b1; sa = child_in; sb = 32'd0;
                        end else phase_in = PH_VOXEL;
                     end
                     PH_VOXEL: begin
                        rec_valid = 1'b1; rec_data.kind = KIND_VOXEL;
                        rec_data.x = {24'd0, w[7:0]};
                        rec_data.y = {24'd0, w[15:8]};
                        rec_data.z = {24'd0, w[23:16]};
                        rec_data.ci = w[31:24];
                        vox_in = vox_in - 32'd1;
                        if (vox_in == 32'd0) begin
                           do_skip = 1'b1; sa = child_in; sb = 32'd0;
                        end
                     end
                     PH_RGBA: begin
                        if (slot_in != 8'd0 && slot_in <= LAST_PALETTE_ENTRY) begin
                           rec_valid = 1'b1; rec_data.kind = KIND_PALETTE;
                           rec_data.ci = slot_in; rec_data.rgba = w;
                           slot_in = slot_in + 8'd1;
                        end else begin
                           slot_in = '0;
                           do_skip = 1'b1; sa = child_in; sb = 32'd0;
                        end
                     end
                     default: phase_in = PH_IDLE;
                  endcase
               end
            end
            if (do_skip) begin
               skip_in = sa; child_in = sb;
               if (skip_in == 32'd0) begin
                  skip_in = child_in; child_in = '0;
               end
               if (skip_in == 32'd0)
                  phase_in = (pos_in < main_end_in) ? PH_CH_ID : PH_END_PEND;
               else
                  phase_in = PH_SKIP;
            end
         end
         if (phase_in == PH_END_PEND && !rec_valid) begin
            rec_valid = 1'b1;
            rec_data = '0;
            rec_data.kind = KIND_END;
            rec_data.ps = flag_in;
            phase_in = PH_IDLE;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_MAGIC; pos_ff <= '0; cnt_ff <= '0; word_ff <= '0;
         main_end_ff <= '0; tag_ff <= '0; cont_ff <= '0; child_ff <= '0;
         skip_ff <= '0; vox_ff <= '0; slot_ff <= '0; hx_ff <= '0; hy_ff <= '0;
         flag_ff <= 1'b0; part_ff <= '0;
      end else begin
         phase_ff <= phase_in; pos_ff <= pos_in; cnt_ff <= cnt_in;
         word_ff <= word_in; main_end_ff <= main_end_in; tag_ff <= tag_in;
         cont_ff <= cont_in; child_ff <= child_in; skip_ff <= skip_in;
         vox_ff <= vox_in; slot_ff <= slot_in; hx_ff <= hx_in; hy_ff <= hy_in;
         flag_ff <= flag_in; part_ff <= part_in;
      end
   end
endmodule

/* hw/rtl/vox_queue.sv */
// Short record queue between the chunk walker and the output side.
module vox_queue #(
   parameter int unsigned DEPTH = vox_pkg::QUEUE_DEPTH
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                wr_valid,
   input  vox_pkg::record_type wr_data,
   output logic                room,
   output logic                rd_valid,
   output vox_pkg::record_type rd_data,
   input  logic                rd_take
);
   import vox_pkg::*;
   localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   record_type        mem_ff [DEPTH];
   logic [AW-1:0]     wp_ff, rp_ff;
   logic [AW:0]       fill_ff;
   logic              do_rd, do_wr;

   // One free slot is kept so room never depends on the output side in-cycle.
   assign room     = fill_ff < (AW+1)'(DEPTH - 1);
   assign rd_valid = fill_ff != '0;
   assign rd_data  = mem_ff[rp_ff];
   assign do_wr    = wr_valid;
   assign do_rd    = rd_take && rd_valid;

   always_ff @(posedge clock) begin
      if (do_wr) mem_ff[wp_ff] <= wr_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= '0; rp_ff <= '0; fill_ff <= '0;
      end else begin
         if (do_wr) wp_ff <= (wp_ff == AW'(DEPTH - 1)) ? '0 : wp_ff + AW'(1);
         if (do_rd) rp_ff <= (rp_ff == AW'(DEPTH - 1)) ? '0 : rp_ff + AW'(1);
         fill_ff <= fill_ff + (AW+1)'(do_wr) - (AW+1)'(do_rd);
      end
   end
endmodule

/* hw/rtl/vox_back.sv */
// Back part: registered output stage that packs records onto the result stream.
module vox_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                q_valid,
   input  vox_pkg::record_type q_data,
   output logic                q_take,
   output logic                out_valid,
   input  logic                out_ready,
   output logic [143:0]        out_data
);
   import vox_pkg::*;

   logic       valid_ff;
   logic [143:0] data_ff;

   assign q_take    = q_valid && (!valid_ff || out_ready);
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_ff @(posedge clock) begin
      if (q_take)
         data_ff <= {4'd0, q_data.ps, q_data.rgba, q_data.ci, q_data.z,
                     q_data.y, q_data.x, q_data.kind};
   end

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else if (q_take) valid_ff <= 1'b1;
      else if (out_ready) valid_ff <= 1'b0;
   end
endmodule
